/* rtl/csed_pkg.sv */
// shared types, codes and character helpers of the c string escape decoder
// no dependencies; used by every rtl file of the block
`default_nettype none

package csed_pkg;

  // output queue depth, must be a power of two and at least 2
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam int SIZE_W = 17;
  localparam int MAXB_W = 16;
  localparam logic [MAXB_W-1:0] MAX_BYTES_RESET = 16'd4093;

  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_LOWER_X   = 8'h78;

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_ESC    = 3'd1,
    MODE_HEX1   = 3'd2,
    MODE_HEX2   = 3'd3,
    MODE_OCT    = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    ERR_NONE    = 3'd0,
    ERR_UNKNOWN = 3'd1,
    ERR_BAD_HEX = 3'd2,
    ERR_CUT     = 3'd3,
    ERR_LONG    = 3'd4
  } err_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       holds_char;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0]        byte_value;
    logic              byte_valid;
    logic              end_of_literal;
    logic [2:0]        error_code;
    logic [SIZE_W-1:0] literal_size;
  } out_item_t;

  // up to two results produced by one decode step
  typedef struct packed {
    logic [1:0] count;
    out_item_t  first;
    out_item_t  second;
  } dec_res_t;

  // {valid, value} of a hex digit of either case
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  function automatic logic is_octal(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h37);
  endfunction

  // {valid, value} of a single-character named escape
  function automatic logic [8:0] named_escape(input logic [7:0] c);
    logic [8:0] r;
    case (c)
      8'h61:   r = {1'b1, 8'd7};    // a
      8'h62:   r = {1'b1, 8'd8};    // b
      8'h74:   r = {1'b1, 8'd9};    // t
      8'h6E:   r = {1'b1, 8'd10};   // n
      8'h76:   r = {1'b1, 8'd11};   // v
      8'h66:   r = {1'b1, 8'd12};   // f
      8'h72:   r = {1'b1, 8'd13};   // r
      8'h65:   r = {1'b1, 8'd27};   // e
      8'h22:   r = {1'b1, 8'd34};   // double quote
      8'h27:   r = {1'b1, 8'd39};   // apostrophe
      8'h5C:   r = {1'b1, 8'd92};   // backslash
      8'h3F:   r = {1'b1, 8'd63};   // question mark
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic out_item_t byte_item(input logic [7:0] b);
    out_item_t r;
    r = '0;
    r.byte_value = b;
    r.byte_valid = 1'b1;
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/csed_decode.sv */
// escape decode step: literal state registers and the per-item decode logic
// depends on csed_pkg
`default_nettype none

module csed_decode (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          fire,
  input  wire csed_pkg::in_item_t            item,
  input  wire logic [csed_pkg::MAXB_W-1:0]   max_bytes,
  output csed_pkg::dec_res_t                 res
);

  csed_pkg::mode_t                   mode_r, mode_nxt;
  csed_pkg::err_t                    err_r, err_nxt;
  logic [8:0]                        acc_r, acc_nxt;
  logic [1:0]                        dcnt_r, dcnt_nxt;
  logic [csed_pkg::SIZE_W-1:0]       bcnt_r, bcnt_nxt;

  logic [7:0]                        c;
  logic [4:0]                        hx;
  logic [8:0]                        ne;
  logic [8:0]                        acc_sh;
  logic                              r0v, r1v, g0, g1;
  logic [7:0]                        r0b, r1b;
  csed_pkg::mode_t                   mode_t1;
  csed_pkg::err_t                    err_t1;
  logic [csed_pkg::SIZE_W-1:0]       cnt1, cnt2, max_ext;
  csed_pkg::dec_res_t                res_c;

  assign c      = item.char_code;
  assign hx     = csed_pkg::hex_digit(c);
  assign ne     = csed_pkg::named_escape(c);
  assign acc_sh = {acc_r[5:0], c[2:0]};
  assign max_ext = {1'b0, max_bytes};

  always_comb begin
    // character step
    mode_t1  = mode_r;
    err_t1   = err_r;
    acc_nxt  = acc_r;
    dcnt_nxt = dcnt_r;
    r0v = 1'b0;
    r0b = 8'd0;
    r1v = 1'b0;
    r1b = 8'd0;
    if (item.holds_char && err_r == csed_pkg::ERR_NONE) begin
      case (mode_r)
        csed_pkg::MODE_ESC: begin
          if (ne[8]) begin
            r0v = 1'b1;
            r0b = ne[7:0];
            mode_t1 = csed_pkg::MODE_NORMAL;
          end else if (c == csed_pkg::CH_LOWER_X) begin
            mode_t1 = csed_pkg::MODE_HEX1;
          end else if (csed_pkg::is_octal(c)) begin
            acc_nxt  = {6'd0, c[2:0]};
            dcnt_nxt = 2'd1;
            mode_t1  = csed_pkg::MODE_OCT;
          end else begin
            err_t1  = csed_pkg::ERR_UNKNOWN;
            mode_t1 = csed_pkg::MODE_NORMAL;
          end
        end
        csed_pkg::MODE_HEX1: begin
          if (hx[4]) begin
            acc_nxt = {5'd0, hx[3:0]};
            mode_t1 = csed_pkg::MODE_HEX2;
          end else begin
            err_t1  = csed_pkg::ERR_BAD_HEX;
            mode_t1 = csed_pkg::MODE_NORMAL;
          end
        end
        csed_pkg::MODE_HEX2: begin
          mode_t1 = csed_pkg::MODE_NORMAL;
          acc_nxt = 9'd0;
          if (hx[4]) begin
            r0v = 1'b1;
            r0b = {acc_r[3:0], hx[3:0]};
          end else begin
            err_t1 = csed_pkg::ERR_BAD_HEX;
          end
        end
        csed_pkg::MODE_OCT: begin
          if (csed_pkg::is_octal(c)) begin
            if (dcnt_r == 2'd2) begin
              r0v = 1'b1;
              r0b = acc_sh[7:0];
              mode_t1  = csed_pkg::MODE_NORMAL;
              acc_nxt  = 9'd0;
              dcnt_nxt = 2'd0;
            end else begin
              acc_nxt  = acc_sh;
              dcnt_nxt = dcnt_r + 2'd1;
            end
          end else begin
            // flush the run, then the ending character in normal mode
            r0v = 1'b1;
            r0b = acc_r[7:0];
            mode_t1  = csed_pkg::MODE_NORMAL;
            acc_nxt  = 9'd0;
            dcnt_nxt = 2'd0;
            if (c == csed_pkg::CH_BACKSLASH) begin
              mode_t1 = csed_pkg::MODE_ESC;
            end else begin
              r1v = 1'b1;
              r1b = c;
            end
          end
        end
        default: begin
          mode_t1 = csed_pkg::MODE_NORMAL;
          if (c == csed_pkg::CH_BACKSLASH) begin
            mode_t1 = csed_pkg::MODE_ESC;
          end else begin
            r0v = 1'b1;
            r0b = c;
          end
        end
      endcase
    end

    // octal run still open at the end is flushed
    if (item.is_last && err_t1 == csed_pkg::ERR_NONE && mode_t1 == csed_pkg::MODE_OCT) begin
      r0v = 1'b1;
      r0b = acc_nxt[7:0];
    end

    // length limit on each byte in order
    err_nxt = err_t1;
    g0 = 1'b0;
    g1 = 1'b0;
    if (r0v && err_nxt == csed_pkg::ERR_NONE) begin
      if (bcnt_r < max_ext) begin
        g0 = 1'b1;
      end else begin
        err_nxt = csed_pkg::ERR_LONG;
      end
    end
    cnt1 = bcnt_r + csed_pkg::SIZE_W'(g0);
    if (r1v && err_nxt == csed_pkg::ERR_NONE) begin
      if (cnt1 < max_ext) begin
        g1 = 1'b1;
      end else begin
        err_nxt = csed_pkg::ERR_LONG;
      end
    end
    cnt2 = cnt1 + csed_pkg::SIZE_W'(g1);

    if (item.is_last && err_nxt == csed_pkg::ERR_NONE &&
        mode_t1 != csed_pkg::MODE_NORMAL && mode_t1 != csed_pkg::MODE_OCT) begin
      err_nxt = csed_pkg::ERR_CUT;
    end

    // result slots
    res_c = '0;
    res_c.count  = {1'b0, g0} + {1'b0, g1};
    res_c.first  = g0 ? csed_pkg::byte_item(r0b) : csed_pkg::byte_item(r1b);
    res_c.second = csed_pkg::byte_item(r1b);
    if (item.is_last) begin
      if (res_c.count == 2'd0) begin
        res_c.count = 2'd1;
        res_c.first = '0;
      end
      if (res_c.count == 2'd2) begin
        res_c.second.end_of_literal = 1'b1;
        res_c.second.error_code     = 3'(err_nxt);
        res_c.second.literal_size   = cnt2 + csed_pkg::SIZE_W'(1);
      end else begin
        res_c.first.end_of_literal = 1'b1;
        res_c.first.error_code     = 3'(err_nxt);
        res_c.first.literal_size   = cnt2 + csed_pkg::SIZE_W'(1);
      end
    end

    mode_nxt = mode_t1;
    bcnt_nxt = cnt2;
    if (item.is_last) begin
      mode_nxt = csed_pkg::MODE_NORMAL;
      err_nxt  = csed_pkg::ERR_NONE;
      acc_nxt  = 9'd0;
      dcnt_nxt = 2'd0;
      bcnt_nxt = '0;
    end

    res = res_c;
    if (!fire) begin
      res.count = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= csed_pkg::MODE_NORMAL;
      err_r  <= csed_pkg::ERR_NONE;
      acc_r  <= 9'd0;
      dcnt_r <= 2'd0;
      bcnt_r <= '0;
    end else if (fire) begin
      mode_r <= mode_nxt;
      err_r  <= err_nxt;
      acc_r  <= acc_nxt;
      dcnt_r <= dcnt_nxt;
      bcnt_r <= bcnt_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/csed_out_queue.sv */
// small result queue: takes up to two items per cycle, gives one per cycle while out_stall is low
// depends on csed_pkg
`default_nettype none

module csed_out_queue (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire csed_pkg::dec_res_t   push,
  output logic                      room,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output csed_pkg::out_item_t       out_data
);

  csed_pkg::out_item_t               q_r [csed_pkg::QDEPTH];
  logic [csed_pkg::QPTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [csed_pkg::QPTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [csed_pkg::QCNT_W-1:0]       cnt_r, cnt_nxt;
  logic                              pop;

  assign out_valid = (cnt_r != '0);
  assign out_data  = q_r[rd_ptr_r];
  assign pop       = out_valid && !out_stall;
  // room for the two results one step may produce
  assign room      = (cnt_r <= csed_pkg::QCNT_W'(csed_pkg::QDEPTH - 2));

  assign wr_ptr_nxt = wr_ptr_r + csed_pkg::QPTR_W'(push.count);
  assign rd_ptr_nxt = rd_ptr_r + csed_pkg::QPTR_W'(pop);
  assign cnt_nxt    = cnt_r + csed_pkg::QCNT_W'(push.count) - csed_pkg::QCNT_W'(pop);

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      q_r[wr_ptr_r] <= push.first;
    end
    if (push.count == 2'd2) begin
      q_r[wr_ptr_r + csed_pkg::QPTR_W'(1)] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/c_string_escape_decoder.sv */
// c string literal escape decoder, one body character per item
// an item waits in the hold register until the queue has room, then decodes into the queue
// throughput: one item per cycle while the queue has room; two bytes of an item go out in turn
// reset (synchronous, rst_n low): literal state cleared, queue empty, max_bytes 4093
// depends on csed_pkg, csed_decode, csed_out_queue
`default_nettype none

module c_string_escape_decoder (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // item input channel
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire csed_pkg::in_item_t     in_data,
  // result channel
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output csed_pkg::out_item_t         out_data,
  // configuration port
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [2:0]             paddr,
  input  wire logic [31:0]            pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  // input register: one item waiting for the decode step
  logic                               hold_v_r, hold_v_nxt;
  csed_pkg::in_item_t                 hold_r;
  logic [csed_pkg::MAXB_W-1:0]        max_bytes_r;

  logic                               room;
  logic                               fire;
  logic                               in_take;
  logic                               cfg_wr;
  csed_pkg::dec_res_t                 dec_res;

  // decode fires when the queue can take two more results
  assign fire     = hold_v_r && room;
  // hold register frees up in the same cycle it fires
  assign in_stall = hold_v_r && !room;
  assign in_take  = in_valid && !in_stall;
  assign hold_v_nxt = in_take || (hold_v_r && !fire);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
    end else begin
      hold_v_r <= hold_v_nxt;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_take) begin
      hold_r <= in_data;
    end
  end

  // register 0 at byte address 0, anything at address 4 and up is ignored
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && !paddr[2];
  assign prdata = paddr[2] ? 32'd0 : {16'd0, max_bytes_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_bytes_r <= csed_pkg::MAX_BYTES_RESET;
    end else if (cfg_wr) begin
      max_bytes_r <= pwdata[csed_pkg::MAXB_W-1:0];
    end
  end

  // escape decoding and per-literal state
  csed_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .item      (hold_r),
    .max_bytes (max_bytes_r),
    .res       (dec_res)
  );

  // results wait here so the input side keeps moving under output stall
  csed_out_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (dec_res),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
